[rtl/csa_pkg.sv]
// Shared types and codes for the command slot allocator.
package csa_pkg;

    localparam int SLOT_AW = 5;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_MARK  = 3'd2,
        CMD_CHECK = 3'd3,
        CMD_READ  = 3'd4
    } csa_cmd_t;

    typedef enum logic [1:0] {
        OUT_OK         = 2'd0,
        OUT_NO_FREE    = 2'd1,
        OUT_BAD_INDEX  = 2'd2,
        OUT_NOT_IN_USE = 2'd3
    } csa_outcome_t;

    typedef struct packed {
        logic signed [15:0] result;
        logic [7:0]         status;
        logic [7:0]         error;
    } csa_rec_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               clr_en;
        logic [SLOT_AW-1:0] addr;
        csa_rec_t           wdata;
    } csa_mem_req_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         slot_index;
        logic signed [15:0] result_code;
        logic [31:0]        active_word;
        logic [7:0]         device_status;
        logic [7:0]         device_error;
    } csa_cmd_word_t;

    typedef struct packed {
        csa_outcome_t outcome;
        logic [4:0]   granted_slot;
        logic [31:0]  newly_done_mask;
        logic [31:0]  busy_mask;
        logic [31:0]  done_mask;
        logic [5:0]   busy_count;
        logic [31:0]  done_total;
        logic         record_done;
        csa_rec_t     record;
    } csa_result_t;

endpackage

[rtl/command_slot_allocator_core.sv]
// Command slot allocator top level: stream ports, output register, sequencer and records.
//
// Allocates, frees, completes and reads up to NUM_SLOTS command slots. One word is taken
// at a time. Allocate, free, unknown commands and mark or read words rejected for their
// slot go from acceptance straight to the result state; mark and read first pass through
// a wait state for the registered read of the record memory, and check first runs a sweep
// that writes each newly completed slot's record through the memory's single write port.
// Each result word sits in an output register, so the next word is accepted while it waits.
module command_slot_allocator_core
    import csa_pkg::*;
#(
    parameter int NUM_SLOTS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot_index[5:0], result_code[21:6], active_word[53:22], device_status[61:54],
    // device_error[69:62], zero pad
    input  logic [71:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // granted_slot[4:0], newly_done_mask[36:5], busy_mask[68:37], done_mask[100:69],
    // busy_count[106:101], done_total[138:107], record_done[139], record_result[155:140],
    // record_status[163:156], record_error[171:164], zero pad
    output logic [175:0] m_tdata,
    // outcome[1:0]
    output logic [1:0]   m_tuser
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    csa_cmd_word_t cmd;
    csa_result_t   res;
    csa_mem_req_t  mem_req;
    csa_rec_t      mem_rdata;
    logic          res_valid;
    logic          res_ready;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [175:0]  m_tdata_reg, m_tdata_next;
    csa_outcome_t  m_tuser_reg, m_tuser_next;

    assign cmd.command       = s_tuser;
    assign cmd.slot_index    = s_tdata[5:0];
    assign cmd.result_code   = s_tdata[21:6];
    assign cmd.active_word   = s_tdata[53:22];
    assign cmd.device_status = s_tdata[61:54];
    assign cmd.device_error  = s_tdata[69:62];

    csa_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    csa_rec_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_rec_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res.outcome;
            m_tdata_next  = {4'b0, res.record.error, res.record.status, res.record.result,
                             res.record_done, res.done_total, res.busy_count, res.done_mask,
                             res.busy_mask, res.newly_done_mask, res.granted_slot};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/csa_rec_mem.sv]
// Per-slot record memory with registered read and per-entry valid bits.
module csa_rec_mem
    import csa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  csa_mem_req_t req,
    output csa_rec_t     rdata
);

    csa_rec_t         mem [DEPTH];
    csa_rec_t         rdata_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rvld_reg;
    logic [AW-1:0]    addr;

    assign addr = req.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // an entry never written, or cleared by free, reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            else if (req.clr_en)
            begin
                vld_reg[addr] <= 1'b0;
            end
            if (req.rd_en)
            begin
                rvld_reg <= vld_reg[addr];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

[rtl/csa_ctrl.sv]
// Command sequencer: slot maps, counters and record memory accesses.
module csa_ctrl
    import csa_pkg::*;
#(
    parameter int NUM_SLOTS = 32,
    parameter int IW        = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  csa_cmd_word_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output csa_result_t   res,
    output csa_mem_req_t  mem_req,
    input  csa_rec_t      mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]   in_use_reg, in_use_next;
    logic [NUM_SLOTS-1:0]   done_map_reg, done_map_next;
    logic [NUM_SLOTS-1:0]   newly_reg, newly_next;
    logic [5:0]             active_cnt_reg, active_cnt_next;
    logic [31:0]            total_reg, total_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    csa_outcome_t           outcome_reg, outcome_next;
    logic [4:0]             granted_reg, granted_next;
    logic                   rdone_reg, rdone_next;
    csa_rec_t               rec_reg, rec_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [SLOT_AW-1:0]     idx_reg, idx_next;
    logic signed [15:0]     res_code_reg, res_code_next;
    logic [7:0]             st_reg, st_next;
    logic [7:0]             er_reg, er_next;

    logic                   idx_ok;
    logic [NUM_SLOTS-1:0]   idx_onehot;
    logic [NUM_SLOTS-1:0]   free_bits;
    logic [NUM_SLOTS-1:0]   lowest_free;
    logic [NUM_SLOTS-1:0]   check_bits;
    logic [4:0]             grant_idx;

    assign idx_ok    = {1'b0, cmd.slot_index} < 7'(NUM_SLOTS);
    assign free_bits = ~in_use_reg;
    // isolate the lowest set bit
    assign lowest_free = free_bits & (~free_bits + 1'b1);
    assign check_bits  = in_use_reg & ~done_map_reg & ~cmd.active_word[NUM_SLOTS-1:0];

    always_comb
    begin
        idx_onehot = '0;
        grant_idx  = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            idx_onehot[i] = idx_ok && (cmd.slot_index == 6'(i));
            grant_idx     = grant_idx | (lowest_free[i] ? 5'(i) : 5'd0);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        done_map_next   = done_map_reg;
        newly_next      = newly_reg;
        active_cnt_next = active_cnt_reg;
        total_next      = total_reg;
        cnt_next        = cnt_reg;
        outcome_next    = outcome_reg;
        granted_next    = granted_reg;
        rdone_next      = rdone_reg;
        rec_next        = rec_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        res_code_next   = res_code_reg;
        st_next         = st_reg;
        er_next         = er_reg;
        mem_req         = '0;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next      = cmd.command;
                    idx_next      = cmd.slot_index[SLOT_AW-1:0];
                    res_code_next = cmd.result_code;
                    st_next       = cmd.device_status;
                    er_next       = cmd.device_error;
                    newly_next    = '0;
                    rdone_next    = 1'b0;
                    rec_next      = '0;
                    granted_next  = '0;
                    outcome_next  = OUT_OK;
                    state_next    = ST_RESULT;
                    mem_req.addr  = cmd.slot_index[SLOT_AW-1:0];
                    case (cmd.command)
                        CMD_ALLOC:
                        begin
                            if (free_bits == '0)
                            begin
                                outcome_next = OUT_NO_FREE;
                            end
                            else
                            begin
                                in_use_next     = in_use_reg | lowest_free;
                                granted_next    = grant_idx;
                                active_cnt_next = active_cnt_reg + 6'd1;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (!idx_ok)
                            begin
                                outcome_next = OUT_BAD_INDEX;
                            end
                            else if ((in_use_reg & idx_onehot) == '0)
                            begin
                                outcome_next = OUT_NOT_IN_USE;
                            end
                            else
                            begin
                                in_use_next     = in_use_reg & ~idx_onehot;
                                done_map_next   = done_map_reg & ~idx_onehot;
                                active_cnt_next = active_cnt_reg - 6'd1;
                                mem_req.clr_en  = 1'b1;
                            end
                        end
                        CMD_MARK:
                        begin
                            if (!idx_ok)
                            begin
                                outcome_next = OUT_BAD_INDEX;
                            end
                            else if ((in_use_reg & idx_onehot) == '0)
                            begin
                                outcome_next = OUT_NOT_IN_USE;
                            end
                            else
                            begin
                                // read the record so status and error survive the merge
                                done_map_next = done_map_reg | idx_onehot;
                                total_next    = total_reg + 32'd1;
                                mem_req.rd_en = 1'b1;
                                state_next    = ST_RDWAIT;
                            end
                        end
                        CMD_CHECK:
                        begin
                            done_map_next = done_map_reg | check_bits;
                            newly_next    = check_bits;
                            cnt_next      = '0;
                            state_next    = ST_SWEEP;
                        end
                        CMD_READ:
                        begin
                            if (!idx_ok)
                            begin
                                outcome_next = OUT_BAD_INDEX;
                            end
                            else
                            begin
                                rdone_next    = |(done_map_reg & idx_onehot);
                                mem_req.rd_en = 1'b1;
                                state_next    = ST_RDWAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                if (cmd_reg == CMD_MARK)
                begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = idx_reg;
                    mem_req.wdata = '{result: res_code_reg,
                                      status: mem_rdata.status,
                                      error:  mem_rdata.error};
                end
                else
                begin
                    rec_next = mem_rdata;
                end
                state_next = ST_RESULT;
            end
            ST_SWEEP:
            begin
                // at most one record write per slot, for newly completed slots only, through the single write port
                if (newly_reg[cnt_reg])
                begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = SLOT_AW'(cnt_reg);
                    mem_req.wdata = '{result: 16'sd0, status: st_reg, error: er_reg};
                    total_next    = total_reg + 32'd1;
                end
                if (cnt_reg == IW'(NUM_SLOTS - 1))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            done_map_reg   <= '0;
            active_cnt_reg <= '0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            done_map_reg   <= done_map_next;
            active_cnt_reg <= active_cnt_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newly_reg    <= newly_next;
        cnt_reg      <= cnt_next;
        outcome_reg  <= outcome_next;
        granted_reg  <= granted_next;
        rdone_reg    <= rdone_next;
        rec_reg      <= rec_next;
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        res_code_reg <= res_code_next;
        st_reg       <= st_next;
        er_reg       <= er_next;
    end

    assign res.outcome         = outcome_reg;
    assign res.granted_slot    = granted_reg;
    assign res.newly_done_mask = 32'(newly_reg);
    assign res.busy_mask       = 32'(in_use_reg);
    assign res.done_mask       = 32'(done_map_reg);
    assign res.busy_count      = active_cnt_reg;
    assign res.done_total      = total_reg;
    assign res.record_done     = rdone_reg;
    assign res.record          = rec_reg;

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_cnt_reg) == 32'($countones(in_use_reg)))
        else $error("busy count out of step with in-use map");

    a_done_within_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done_map_reg & ~in_use_reg) == '0)
        else $error("completed slot that is not in use");

    a_check_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.command == CMD_CHECK) |=> state_reg == ST_SWEEP)
        else $error("check did not start the record sweep");

    a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !mem_req.rd_en && !mem_req.clr_en)
        else $error("record memory read or cleared during sweep");

endmodule

[tb/command_slot_allocator_core_tb.sv]
// Self-checking stream testbench for the command slot allocator: table, random traffic, scoreboard.
`timescale 1ns / 1ps

module command_slot_allocator_core_tb;
    import csa_pkg::*;

    localparam int SLOTS        = 32;
    localparam int RANDOM_WORDS = 1125;
    localparam int NUM_DIR      = 25;
    localparam int HOLD_AT      = 400;   // reply count at which the sink backs off
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    // command codes the block does not decode
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        csa_outcome_t outcome;
        logic [4:0]   granted;
        logic [31:0]  newly;
        logic [31:0]  busy;
        logic [31:0]  done;
        logic [5:0]   count;
        logic [31:0]  total;
        logic         rdone;
        logic [15:0]  rres;
        logic [7:0]   rstat;
        logic [7:0]   rerr;
    } slot_reply_t;

    typedef struct packed {
        logic [2:0]   cmd;
        logic [5:0]   idx;
        logic [15:0]  code;
        logic [31:0]  act;
        logic [7:0]   st;
        logic [7:0]   er;
        logic         fixed;     // outcome and grant below are the expected values
        csa_outcome_t outc;
        logic [4:0]   grant;
    } dir_row_t;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} mix_phase_t;

    localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
        '{CMD_READ,  6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_FREE,  6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_NOT_IN_USE, 5'd0},
        '{CMD_MARK,  6'd31, 16'h7fff, 32'h0,        8'h00, 8'h00, 1'b1, OUT_NOT_IN_USE, 5'd0},
        '{CMD_FREE,  6'd63, 16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_BAD_INDEX,  5'd0},
        '{CMD_MARK,  6'd32, 16'h8000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_BAD_INDEX,  5'd0},
        '{CMD_READ,  6'd63, 16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_BAD_INDEX,  5'd0},
        '{CMD_ALLOC, 6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_ALLOC, 6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd1},
        '{CMD_ALLOC, 6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd2},
        '{CMD_MARK,  6'd0,  16'h8000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_MARK,  6'd0,  16'h7fff, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_CHECK, 6'd0,  16'h0000, 32'hfffffffb, 8'hff, 8'h00, 1'b0, OUT_OK,         5'd0},
        '{CMD_CHECK, 6'd0,  16'hffff, 32'h0,        8'h00, 8'hff, 1'b0, OUT_OK,         5'd0},
        '{CMD_READ,  6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b0, OUT_OK,         5'd0},
        '{CMD_READ,  6'd2,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b0, OUT_OK,         5'd0},
        '{CMD_READ,  6'd1,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b0, OUT_OK,         5'd0},
        '{CMD_FREE,  6'd1,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_READ,  6'd1,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b0, OUT_OK,         5'd0},
        '{CMD_ALLOC, 6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd1},
        '{CMD_CHECK, 6'd0,  16'h0000, 32'hffffffff, 8'ha5, 8'h5a, 1'b0, OUT_OK,         5'd0},
        '{CMD_RSVD_LO,  6'd63, 16'hffff, 32'hffffffff, 8'hff, 8'hff, 1'b1, OUT_OK,      5'd0},
        '{CMD_RSVD_HI,  6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,      5'd0},
        '{CMD_RSVD_MID, 6'd31, 16'h8000, 32'h0,        8'hff, 8'h00, 1'b1, OUT_OK,      5'd0},
        '{CMD_FREE,  6'd2,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0},
        '{CMD_FREE,  6'd0,  16'h0000, 32'h0,        8'h00, 8'h00, 1'b1, OUT_OK,         5'd0}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic [1:0]   m_tuser;

    // slot table mirror
    logic [31:0] busy_map;
    logic [31:0] done_map;
    logic [15:0] rec_result [SLOTS];
    logic [7:0]  rec_status [SLOTS];
    logic [7:0]  rec_error  [SLOTS];
    logic [5:0]  live_slots;
    logic [31:0] retire_count;

    slot_reply_t pending_replies [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          src_burst = 1'b0;
    bit          sink_burst = 1'b0;

    command_slot_allocator_core #(.NUM_SLOTS(SLOTS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic slot_reply_t predict_slot_reply(input logic [2:0] cmd,
                                                       input logic [5:0] idx,
                                                       input logic [15:0] code,
                                                       input logic [31:0] act,
                                                       input logic [7:0] st,
                                                       input logic [7:0] er);
        slot_reply_t r;
        logic        in_range;
        logic [4:0]  s;
        logic [31:0] bitm;
        bit          found;
        r        = '0;
        r.outcome = OUT_OK;
        in_range = idx < SLOTS;
        s        = idx[4:0];
        bitm     = in_range ? (32'd1 << s) : 32'd0;
        found    = 1'b0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (&busy_map)
                    r.outcome = OUT_NO_FREE;
                else
                begin
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (!found && !busy_map[k])
                        begin
                            found      = 1'b1;
                            r.granted  = 5'(k);
                            busy_map[k] = 1'b1;
                        end
                    end
                    live_slots = live_slots + 6'd1;
                end
            end
            CMD_FREE:
            begin
                if (!in_range)
                    r.outcome = OUT_BAD_INDEX;
                else if ((busy_map & bitm) == 0)
                    r.outcome = OUT_NOT_IN_USE;
                else
                begin
                    busy_map      &= ~bitm;
                    done_map      &= ~bitm;
                    live_slots     = live_slots - 6'd1;
                    rec_result[s] = '0;
                    rec_status[s] = '0;
                    rec_error[s]  = '0;
                end
            end
            CMD_MARK:
            begin
                if (!in_range)
                    r.outcome = OUT_BAD_INDEX;
                else if ((busy_map & bitm) == 0)
                    r.outcome = OUT_NOT_IN_USE;
                else
                begin
                    done_map      |= bitm;
                    rec_result[s]  = code;
                    retire_count   = retire_count + 32'd1;
                end
            end
            CMD_CHECK:
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (busy_map[k] && !done_map[k] && !act[k])
                    begin
                        rec_status[k] = st;
                        rec_error[k]  = er;
                        rec_result[k] = '0;
                        done_map[k]   = 1'b1;
                        retire_count  = retire_count + 32'd1;
                        r.newly[k]    = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                if (!in_range)
                    r.outcome = OUT_BAD_INDEX;
                else
                begin
                    r.rdone = done_map[s];
                    r.rres  = rec_result[s];
                    r.rstat = rec_status[s];
                    r.rerr  = rec_error[s];
                end
            end
            default: ;
        endcase
        r.busy  = busy_map;
        r.done  = done_map;
        r.count = live_slots;
        r.total = retire_count;
        return r;
    endfunction

    // returns at the clock edge where the word is taken
    task automatic offer_word(input logic [2:0] cmd, input logic [5:0] idx,
                              input logic [15:0] code, input logic [31:0] act,
                              input logic [7:0] st, input logic [7:0] er,
                              input logic fixed, input csa_outcome_t outc,
                              input logic [4:0] grant);
        int          gap;
        slot_reply_t r;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, er, st, act, code, idx};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        r = predict_slot_reply(cmd, idx, code, act, st, er);
        if (fixed)
        begin
            r.outcome = outc;
            r.granted = grant;
        end
        pending_replies.push_back(r);
    endtask

    function automatic logic [2:0] pick_command(input mix_phase_t ph);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                return roll < 60 ? CMD_ALLOC : roll < 65 ? CMD_FREE : roll < 75 ? CMD_MARK :
                       roll < 85 ? CMD_CHECK : roll < 97 ? CMD_READ :
                       3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            PH_DRAIN:
                return roll < 10 ? CMD_ALLOC : roll < 50 ? CMD_FREE : roll < 62 ? CMD_MARK :
                       roll < 78 ? CMD_CHECK : roll < 97 ? CMD_READ :
                       3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            default:
                return roll < 25 ? CMD_ALLOC : roll < 45 ? CMD_FREE : roll < 60 ? CMD_MARK :
                       roll < 75 ? CMD_CHECK : roll < 96 ? CMD_READ :
                       3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        endcase
    endfunction

    // mostly slots that are in use, some random in-range ones, some out of range
    function automatic logic [5:0] pick_slot();
        int roll;
        int start;
        int s;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return 6'($urandom_range(SLOTS, 63));
        if (roll < 70 && busy_map != 0)
        begin
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
            begin
                s = (start + k) % SLOTS;
                if (busy_map[s])
                    return 6'(s);
            end
        end
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    initial
    begin
        mix_phase_t  phase;
        int          phase_left;
        logic [2:0]  cmd;
        logic [15:0] code;
        logic [31:0] act;
        busy_map     = '0;
        done_map     = '0;
        live_slots   = '0;
        retire_count = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            rec_result[k] = '0;
            rec_status[k] = '0;
            rec_error[k]  = '0;
        end
        phase      = PH_FILL;
        phase_left = 80;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            offer_word(DIR_ROWS[i].cmd, DIR_ROWS[i].idx, DIR_ROWS[i].code, DIR_ROWS[i].act,
                       DIR_ROWS[i].st, DIR_ROWS[i].er, DIR_ROWS[i].fixed, DIR_ROWS[i].outc,
                       DIR_ROWS[i].grant);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                phase      = mix_phase_t'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            if (n % 40 == 0)
                src_burst = ($urandom_range(0, 2) == 0);
            cmd  = pick_command(phase);
            code = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff)
                                               : 16'($urandom);
            case ($urandom_range(0, 3))
                0:       act = $urandom;
                1:       act = $urandom | $urandom;
                2:       act = ~(32'd1 << $urandom_range(0, 31));
                default: act = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
            endcase
            offer_word(cmd, pick_slot(), code, act, 8'($urandom), 8'($urandom),
                       1'b0, OUT_OK, 5'd0);
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        int           stall;
        int           taken;
        logic [175:0] word;
        logic [1:0]   tag;
        slot_reply_t  want;
        taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                sink_burst = ($urandom_range(0, 2) == 0);
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid)
                @(negedge clk);
            word = m_tdata;
            tag  = m_tuser;
            @(posedge clk);
            taken++;
            if (pending_replies.size() == 0)
            begin
                $error("reply word with nothing pending: outcome %0h data %0h", tag, word);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("outcome",         32'(want.outcome), 32'(tag));
                check_field("granted_slot",    32'(want.granted), 32'(word[4:0]));
                check_field("newly_done_mask", want.newly,        word[36:5]);
                check_field("busy_mask",       want.busy,         word[68:37]);
                check_field("done_mask",       want.done,         word[100:69]);
                check_field("busy_count",      32'(want.count),   32'(word[106:101]));
                check_field("done_total",      want.total,        word[138:107]);
                check_field("record_done",     32'(want.rdone),   32'(word[139]));
                check_field("record_result",   32'(want.rres),    32'(word[155:140]));
                check_field("record_status",   32'(want.rstat),   32'(word[163:156]));
                check_field("record_error",    32'(want.rerr),    32'(word[171:164]));
            end
        end
    end

    // stall watchdog: handshakes seen at the falling edge complete on the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
